// ===== hw/rtl/psds_pkg.sv =====
// Shared types and constants for the per-slot duration statistics block.
// Holds the item structs, request codes, the controller state type and
// the controller/datapath command and status structs.
package psds_pkg;

    localparam int DEF_NUM_SLOTS = 16;
    localparam int DEF_WINDOW    = 8;

    localparam logic [31:0] WRAP_RESET = 32'd65536;
    localparam logic [30:0] MIN_INIT   = 31'h0000ffff;
    localparam logic [30:0] SAT31      = 31'h7fffffff;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_ARM   = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  slot;
        logic [31:0] timer_value;
        logic [31:0] overflow_count;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  result_slot;
        logic [30:0] elapsed;
        logic [30:0] average;
        logic [30:0] minimum;
        logic [30:0] maximum;
        logic [3:0]  fill;
        logic        cleared_after;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_SUM,
        S_ELAP,
        S_UPD,
        S_DIV,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_wr;
        logic rd_win;
        logic mul;
        logic pos;
        logic elap;
        logic upd;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_go;
        logic is_start;
        logic div_done;
        logic out_busy;
    } t_status;

endpackage

// ===== hw/rtl/per_slot_duration_statistics_core.sv =====
// Top level of the per-slot duration statistics block.
// Depends on psds_pkg, psds_ctrl and psds_dp.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_stall    i_item (t_in_item)
//   output   out        o_valid / i_stall    o_item (t_out_item)
//   config   in         i_cfg_wr_en          i_cfg_wr_data (timer_wrap)
//
// A stop item goes through the read, multiply, sum, elapsed, update, divide and
// load states; the divide state forms the average, one quotient bit per cycle.
// Start items read and write the slot record; other items are taken in idle.
// Reset is synchronous and active low; it marks every slot as cleared.
// A finished result waits in the output register while the next item is taken.
module per_slot_duration_statistics_core
    import psds_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int WINDOW    = DEF_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item
);

    t_cmd    cmd;
    t_status status;

    psds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    psds_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .WINDOW    (WINDOW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (i_item),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_item        (o_item)
    );

endmodule

// ===== hw/rtl/psds_ctrl.sv =====
// Sequencing controller for the per-slot duration statistics block.
// Depends on psds_pkg for the state, command and status types.
module psds_ctrl
    import psds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_status.in_go) n_state = S_READ;
            end
            S_READ: begin
                n_state = i_status.is_start ? S_IDLE : S_MUL;
            end
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_ELAP;
            S_ELAP: n_state = S_UPD;
            S_UPD:  n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            S_READ: begin
                o_cmd.start_wr = i_status.is_start;
                o_cmd.rd_win   = !i_status.is_start;
            end
            S_MUL:  o_cmd.mul  = 1'b1;
            S_SUM:  o_cmd.pos  = 1'b1;
            S_ELAP: o_cmd.elap = 1'b1;
            S_UPD:  o_cmd.upd  = 1'b1;
            S_DIV:  o_cmd.div_step = !i_status.div_done;
            S_LOAD: o_cmd.load_out = !i_status.out_busy;
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_read_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ($past(r_state) == S_IDLE))
        else $error("read state not entered from idle");

    a_upd_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state == S_DIV))
        else $error("update not followed by divide");

    a_load_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && !i_status.out_busy) |=> (r_state == S_IDLE))
        else $error("load did not return to idle");
`endif

endmodule

// ===== hw/rtl/psds_dp.sv =====
// Datapath for the per-slot duration statistics block: slot records, window
// memory, elapsed-time arithmetic, serial divider and output register.
// Depends on psds_pkg for item structs, command and status types.
module psds_dp
    import psds_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int WINDOW    = DEF_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  t_in_item    i_item,
    input  logic        i_stall,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic        o_valid,
    output t_out_item   o_item
);

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int SUM_W   = 31 + $clog2(WINDOW);
    localparam int WADDR_W = (NUM_SLOTS * WINDOW > 1) ? $clog2(NUM_SLOTS * WINDOW) : 1;
    localparam int CNT_W   = $clog2(SUM_W + 1);

    logic [31:0]       mem_st   [NUM_SLOTS];
    logic [31:0]       mem_so   [NUM_SLOTS];
    logic [SUM_W-1:0]  mem_sum  [NUM_SLOTS];
    logic [30:0]       mem_min  [NUM_SLOTS];
    logic [30:0]       mem_max  [NUM_SLOTS];
    logic [FILL_W-1:0] mem_fill [NUM_SLOTS];
    logic [POS_W-1:0]  mem_wpos [NUM_SLOTS];
    logic [30:0]       mem_win  [NUM_SLOTS * WINDOW];

    logic [31:0]       r_wrap;
    t_in_item          r_in;
    logic              r_pending;
    logic [NUM_SLOTS-1:0] r_slot_vld;

    logic [31:0]       r_rd_st;
    logic [31:0]       r_rd_so;
    logic [SUM_W-1:0]  r_rd_sum;
    logic [30:0]       r_rd_min;
    logic [30:0]       r_rd_max;
    logic [FILL_W-1:0] r_rd_fill;
    logic [POS_W-1:0]  r_rd_wpos;
    logic [30:0]       r_rd_old;

    logic [31:0]       r_st;
    logic [31:0]       r_so;
    logic [SUM_W-1:0]  r_sum;
    logic [30:0]       r_min;
    logic [30:0]       r_max;
    logic [FILL_W-1:0] r_fill;
    logic [POS_W-1:0]  r_wpos;
    logic [63:0]       r_prod;
    logic [64:0]       r_pos;
    logic [65:0]       r_pos2;
    logic [30:0]       r_v;

    logic [FILL_W-1:0] r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;

    t_out_item         r_out;
    logic              r_out_vld;

    logic              in_slot_ok;
    logic [SLOT_W-1:0] in_idx;
    logic [SLOT_W-1:0] cur_idx;
    logic [WADDR_W-1:0] win_addr;
    logic              e_vld;
    logic [31:0]       step;
    logic [31:0]       ovf_delta;

    logic [SUM_W-1:0]  e_sum;
    logic [30:0]       e_min;
    logic [30:0]       e_max;
    logic [FILL_W-1:0] e_fill;
    logic [POS_W-1:0]  e_wpos;

    logic [65:0]       d1;
    logic [65:0]       d2;
    logic [65:0]       v_raw;

    logic              full;
    logic [SUM_W-1:0]  n_sum;
    logic [30:0]       n_min;
    logic [30:0]       n_max;
    logic [FILL_W-1:0] n_fill;
    logic [POS_W-1:0]  n_wpos;

    logic [FILL_W:0]   rem_sh;
    logic [FILL_W:0]   rem_diff;
    logic              rem_ge;

    assign in_slot_ok = (32'(i_item.slot) < NUM_SLOTS);
    assign in_idx     = SLOT_W'(i_item.slot);
    assign cur_idx    = SLOT_W'(r_in.slot);
    assign step       = (r_wrap == 32'd0) ? 32'd0 : r_wrap - 32'd1;
    assign ovf_delta  = r_in.overflow_count - r_so;

    assign e_vld  = r_slot_vld[cur_idx];
    assign e_sum  = e_vld ? r_rd_sum  : '0;
    assign e_min  = e_vld ? r_rd_min  : MIN_INIT;
    assign e_max  = e_vld ? r_rd_max  : '0;
    assign e_fill = e_vld ? r_rd_fill : '0;
    assign e_wpos = e_vld ? r_rd_wpos : '0;

    assign win_addr = WADDR_W'(32'(cur_idx) * WINDOW + 32'(r_wpos));

    assign d1    = {1'b0, r_pos} - {34'd0, r_st};
    assign d2    = r_pos2 - {34'd0, r_st};
    assign v_raw = ({1'b0, r_pos} >= {34'd0, r_st}) ? d1 :
                   ((r_pos2 >= {34'd0, r_st}) ? d2 : 66'd0);

    assign full   = (32'(r_fill) >= WINDOW);
    assign n_sum  = full ? (r_sum - SUM_W'(r_rd_old) + SUM_W'(r_v)) : (r_sum + SUM_W'(r_v));
    assign n_min  = (r_v < r_min) ? r_v : r_min;
    assign n_max  = (r_v > r_max) ? r_v : r_max;
    assign n_fill = full ? r_fill : r_fill + FILL_W'(1);
    assign n_wpos = (32'(r_wpos) + 1 >= WINDOW) ? '0 : r_wpos + POS_W'(1);

    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_fill});
    assign rem_diff = rem_sh - {1'b0, r_fill};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= WRAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_wrap <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_item;
        end
        if (i_cmd.accept && in_slot_ok) begin
            r_rd_st   <= mem_st[in_idx];
            r_rd_so   <= mem_so[in_idx];
            r_rd_sum  <= mem_sum[in_idx];
            r_rd_min  <= mem_min[in_idx];
            r_rd_max  <= mem_max[in_idx];
            r_rd_fill <= mem_fill[in_idx];
            r_rd_wpos <= mem_wpos[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_wr) begin
            mem_st[cur_idx]   <= r_in.timer_value;
            mem_so[cur_idx]   <= r_in.overflow_count;
            mem_sum[cur_idx]  <= e_sum;
            mem_min[cur_idx]  <= e_min;
            mem_max[cur_idx]  <= e_max;
            mem_fill[cur_idx] <= e_fill;
            mem_wpos[cur_idx] <= e_wpos;
        end else if (i_cmd.upd) begin
            mem_st[cur_idx]   <= r_st;
            mem_so[cur_idx]   <= r_so;
            mem_sum[cur_idx]  <= n_sum;
            mem_min[cur_idx]  <= n_min;
            mem_max[cur_idx]  <= n_max;
            mem_fill[cur_idx] <= n_fill;
            mem_wpos[cur_idx] <= n_wpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            mem_win[win_addr] <= r_v;
        end
        if (i_cmd.mul) begin
            r_rd_old <= mem_win[win_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_win) begin
            r_st   <= e_vld ? r_rd_st : '0;
            r_so   <= e_vld ? r_rd_so : '0;
            r_sum  <= e_sum;
            r_min  <= e_min;
            r_max  <= e_max;
            r_fill <= e_fill;
            r_wpos <= e_wpos;
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(ovf_delta) * 64'(step);
        end
        if (i_cmd.pos) begin
            r_pos  <= {33'd0, r_in.timer_value} + {1'b0, r_prod};
            r_pos2 <= {34'd0, r_in.timer_value} + {2'b0, r_prod} + {34'd0, step};
        end
        if (i_cmd.elap) begin
            r_v <= (v_raw > {35'd0, SAT31}) ? SAT31 : v_raw[30:0];
        end
        if (i_cmd.upd) begin
            r_min  <= n_min;
            r_max  <= n_max;
            r_fill <= n_fill;
            r_quo  <= n_sum;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_diff[FILL_W-1:0] : rem_sh[FILL_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.upd) begin
            r_cnt <= CNT_W'(SUM_W);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 1'b0;
            r_slot_vld <= '0;
        end else begin
            if (i_cmd.accept && i_item.req_type == REQ_ARM) begin
                r_pending <= 1'b1;
            end
            if (i_cmd.start_wr || i_cmd.upd) begin
                r_slot_vld[cur_idx] <= 1'b1;
            end
            if (i_cmd.load_out && r_pending) begin
                r_pending  <= 1'b0;
                r_slot_vld <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.result_slot   <= r_in.slot;
            r_out.elapsed       <= r_v;
            r_out.average       <= r_quo[30:0];
            r_out.minimum       <= r_min;
            r_out.maximum       <= r_max;
            r_out.fill          <= 4'(r_fill);
            r_out.cleared_after <= r_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_status.in_go    = in_slot_ok &&
                               (i_item.req_type == REQ_START || i_item.req_type == REQ_STOP);
    assign o_status.is_start = (r_in.req_type == REQ_START);
    assign o_status.div_done = (r_cnt == '0);
    assign o_status.out_busy = r_out_vld && i_stall;

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule
